### src/bdnr_pkg.sv
package bdnr_pkg;

  localparam int unsigned MAX_DIGITS   = 10;
  localparam int unsigned GLYPH_WIDTH  = 3;
  localparam int unsigned GLYPH_HEIGHT = 2;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned BCD_W        = 4 * MAX_DIGITS;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  typedef struct packed {
    logic [5:0]  column_start;
    logic [1:0]  row_start;
    logic [31:0] value;
    logic [3:0]  digit_count;
    logic        show_leading_zeros;
  } in_word_t;

  typedef struct packed {
    logic [6:0] cell_column;
    logic [2:0] cell_row;
    logic [7:0] cell_code;
    logic       last_cell;
  } out_word_t;

  // Big-font cell code for digit d, glyph row r, glyph column c.
  function automatic logic [7:0] glyph_code(logic [3:0] d, logic r, logic [1:0] c);
    logic [7:0] code;
    code = SPACE_CODE;
    unique case ({d, r, c})
      // digit 0
      7'b0000_0_00: code = 8'd1;
      7'b0000_0_01: code = 8'd7;
      7'b0000_0_10: code = 8'd0;
      7'b0000_1_00: code = 8'd1;
      7'b0000_1_01: code = 8'd5;
      7'b0000_1_10: code = 8'd0;
      // digit 1
      7'b0001_0_01: code = 8'd1;
      7'b0001_1_01: code = 8'd1;
      // digit 2
      7'b0010_0_00: code = 8'd4;
      7'b0010_0_01: code = 8'd2;
      7'b0010_0_10: code = 8'd0;
      7'b0010_1_00: code = 8'd1;
      7'b0010_1_01: code = 8'd5;
      7'b0010_1_10: code = 8'd5;
      // digit 3
      7'b0011_0_00: code = 8'd4;
      7'b0011_0_01: code = 8'd2;
      7'b0011_0_10: code = 8'd0;
      7'b0011_1_00: code = 8'd6;
      7'b0011_1_01: code = 8'd5;
      7'b0011_1_10: code = 8'd0;
      // digit 4
      7'b0100_0_00: code = 8'd1;
      7'b0100_0_01: code = 8'd5;
      7'b0100_0_10: code = 8'd0;
      7'b0100_1_10: code = 8'd0;
      // digit 5
      7'b0101_0_00: code = 8'd1;
      7'b0101_0_01: code = 8'd2;
      7'b0101_0_10: code = 8'd3;
      7'b0101_1_00: code = 8'd6;
      7'b0101_1_01: code = 8'd5;
      7'b0101_1_10: code = 8'd0;
      // digit 6
      7'b0110_0_00: code = 8'd1;
      7'b0110_0_01: code = 8'd2;
      7'b0110_0_10: code = 8'd3;
      7'b0110_1_00: code = 8'd1;
      7'b0110_1_01: code = 8'd5;
      7'b0110_1_10: code = 8'd0;
      // digit 7
      7'b0111_0_00: code = 8'd1;
      7'b0111_0_01: code = 8'd7;
      7'b0111_0_10: code = 8'd0;
      7'b0111_1_10: code = 8'd0;
      // digit 8
      7'b1000_0_00: code = 8'd1;
      7'b1000_0_01: code = 8'd2;
      7'b1000_0_10: code = 8'd0;
      7'b1000_1_00: code = 8'd1;
      7'b1000_1_01: code = 8'd5;
      7'b1000_1_10: code = 8'd0;
      // digit 9
      7'b1001_0_00: code = 8'd1;
      7'b1001_0_01: code = 8'd2;
      7'b1001_0_10: code = 8'd0;
      7'b1001_1_00: code = 8'd6;
      7'b1001_1_01: code = 8'd5;
      7'b1001_1_10: code = 8'd0;
      default:      code = SPACE_CODE;
    endcase
    return code;
  endfunction

endpackage

### src/big_digit_number_renderer_top.sv
// Big-digit renderer: turns an unsigned 32-bit number into character-cell
// writes for a text LCD, each digit drawn as a 3x2 big glyph.
//
// Input channel (in_valid_i/in_ready_o, in_word_i): one word per number.
// Output channel (out_valid_o/out_ready_i, out_word_o): one word per cell,
// 6 cells per shown digit, last_cell set on the final one. digit_count 0
// gives no cells; counts above 10 are treated as 10.
//
// Timing: the binary-to-BCD converter is a shift-and-add-3 register that
// takes one value bit per cycle. The BCD register is then shifted one
// digit per cycle to drop the unshown high digits, and cells leave one per
// cycle while the receiver is ready, from a single output register.
// in_ready_o is high only between numbers, though the last cell of the
// previous number may still sit in the output register.
//
// Reset (rst_ni low, asynchronous) returns to idle and drops out_valid_o.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; no cell is skipped or repeated.
module big_digit_number_renderer_top
  import bdnr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_EMIT
  } state_e;

  localparam logic [3:0] MaxDig   = 4'(MAX_DIGITS);
  localparam logic [1:0] LastCol  = 2'(GLYPH_WIDTH - 1);
  localparam logic       LastRow  = 1'(GLYPH_HEIGHT - 1);
  localparam logic [6:0] GlyphW   = 7'(GLYPH_WIDTH);
  localparam logic [4:0] LastBit  = 5'(VALUE_W - 1);

  state_e            state_q;
  logic [VALUE_W-1:0] bin_q;     // value bits still to shift in, MSB first
  logic [BCD_W-1:0]  bcd_q;      // ten BCD digits, leftmost shown digit on top after align
  logic [4:0]        bit_q;      // conversion step
  logic [3:0]        align_q;    // high digits still to drop
  logic [3:0]        remain_q;   // digits still to emit, including current
  logic [6:0]        base_q;     // column of current glyph's left cell
  logic [2:0]        row_q;      // top row of the field
  logic              r_q;
  logic [1:0]        c_q;
  logic              drawing_q;  // a non-blank digit has been drawn (or zeros shown)
  logic              out_valid_q;
  out_word_t         out_q;

  logic [3:0]        cnt_sat;
  logic [BCD_W-1:0]  bcd_adj;
  logic [3:0]        cur_digit;
  logic              blank;
  logic              out_free;
  out_word_t         out_d;

  assign cnt_sat = (in_word_i.digit_count > MaxDig) ? MaxDig : in_word_i.digit_count;

  // Add-3 correction on every BCD digit before the next shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  assign cur_digit = bcd_q[BCD_W-1 -: 4];
  assign blank     = (cur_digit == 4'd0) && !drawing_q && (remain_q != 4'd1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.cell_column = base_q + {5'd0, c_q};
    out_d.cell_row    = row_q + {2'd0, r_q};
    out_d.cell_code   = blank ? SPACE_CODE : glyph_code(cur_digit, r_q, c_q);
    out_d.last_cell   = (remain_q == 4'd1) && (r_q == LastRow) && (c_q == LastCol);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      bin_q       <= '0;
      bcd_q       <= '0;
      bit_q       <= '0;
      align_q     <= '0;
      remain_q    <= '0;
      base_q      <= '0;
      row_q       <= '0;
      r_q         <= 1'b0;
      c_q         <= '0;
      drawing_q   <= 1'b0;
    end else begin
      // output register: loaded while emitting, cleared once taken
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            bin_q     <= in_word_i.value;
            bcd_q     <= '0;
            bit_q     <= '0;
            align_q   <= MaxDig - cnt_sat;
            remain_q  <= cnt_sat;
            base_q    <= {1'b0, in_word_i.column_start};
            row_q     <= {1'b0, in_word_i.row_start};
            r_q       <= 1'b0;
            c_q       <= '0;
            drawing_q <= in_word_i.show_leading_zeros;
            if (cnt_sat != 4'd0) begin
              state_q <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
          bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
          bit_q <= bit_q + 5'd1;
          if (bit_q == LastBit) begin
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (align_q == 4'd0) begin
            state_q <= ST_EMIT;
          end else begin
            bcd_q   <= {bcd_q[BCD_W-5:0], 4'd0};
            align_q <= align_q - 4'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q <= out_d;
            if (c_q == LastCol) begin
              c_q <= '0;
              if (r_q == LastRow) begin
                r_q       <= 1'b0;
                bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
                base_q    <= base_q + GlyphW;
                drawing_q <= drawing_q | !blank;
                remain_q  <= remain_q - 4'd1;
                if (remain_q == 4'd1) begin
                  state_q <= ST_IDLE;
                end
              end else begin
                r_q <= r_q + 1'b1;
              end
            end else begin
              c_q <= c_q + 2'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A number with no digits is dropped without leaving idle.
  a_zero_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.digit_count == 4'd0) |=> in_ready_o)
    else $error("zero-digit number left idle");

  // Any other number starts a conversion.
  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.digit_count != 4'd0) |=> !in_ready_o)
    else $error("number with digits not converted");

  // Cell codes are stroke codes or the space code.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.cell_code < 8'd8) || (out_word_o.cell_code == SPACE_CODE))
    else $error("bad cell code");

  // Emission only while digits remain.
  a_emit_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (remain_q != 4'd0) && (remain_q <= MaxDig))
    else $error("emit with no digits left");

endmodule
